// File: src/cpo_pkg.sv
package cpo_pkg;

    localparam int unsigned MAX_POINTS_DEF  = 1024;
    localparam int unsigned MAX_CURVES_DEF  = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 21;
    localparam int CIDX_W  = 8;
    localparam int START_W = 10;
    localparam int SIZE_W  = 11;
    localparam int NB_W    = 10;
    localparam int CFG_W   = 11;

    // signed working width of point arithmetic: index, offset and start differences
    localparam int WORK_W = IDX_W + 3;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_MAP_LOAD   = 2'd0,
        FUNC_CURVE_LOAD = 2'd1,
        FUNC_QUERY      = 2'd2
    } func_t;

    typedef struct packed {
        logic               closed;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } curve_t;

    // classified query handed from the front to the back
    typedef struct packed {
        logic                     closed;
        logic                     ok;
        logic [START_W-1:0]       start;
        logic [SIZE_W-1:0]        size;
        logic [NB_W-1:0]          nb_open;
        logic signed [WORK_W-1:0] x;
    } work_t;

    // one stage of the remainder pipeline
    typedef struct packed {
        logic               closed;
        logic               ok;
        logic               neg;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic [NB_W-1:0]    nb_open;
        logic [WORK_W-1:0]  mag;
        logic [SIZE_W:0]    rem;
    } div_t;

endpackage

// File: src/cpo_in_if.sv
interface cpo_in_if;
    logic                                valid;
    logic                                ready;
    logic [cpo_pkg::FUNC_W-1:0]          func;
    logic signed [cpo_pkg::IDX_W-1:0]    point_index;
    logic signed [cpo_pkg::IDX_W-1:0]    offset;
    logic [cpo_pkg::CIDX_W-1:0]          curve_index;
    logic [cpo_pkg::START_W-1:0]         curve_start;
    logic [cpo_pkg::SIZE_W-1:0]          curve_size;
    logic                                cyclic;

    modport source (
        output valid, func, point_index, offset, curve_index, curve_start, curve_size, cyclic,
        input  ready
    );

    modport sink (
        input  valid, func, point_index, offset, curve_index, curve_start, curve_size, cyclic,
        output ready
    );
endinterface

// File: src/cpo_out_if.sv
interface cpo_out_if;
    logic                       valid;
    logic                       ready;
    logic [cpo_pkg::NB_W-1:0]   neighbor_index;
    logic                       valid_offset;

    modport source (
        output valid, neighbor_index, valid_offset,
        input  ready
    );

    modport sink (
        input  valid, neighbor_index, valid_offset,
        output ready
    );
endinterface

// File: src/cpo_front.sv
module cpo_front #(
    parameter int unsigned MAX_POINTS  = cpo_pkg::MAX_POINTS_DEF,
    parameter int unsigned MAX_CURVES  = cpo_pkg::MAX_CURVES_DEF,
    parameter int unsigned QUEUE_DEPTH = cpo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cpo_in_if.sink                               item,
    input  logic [cpo_pkg::CFG_W-1:0]            points_in_use,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_count,
    output logic                                 push,
    output cpo_pkg::work_t                       push_data
);

    localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int W    = cpo_pkg::WORK_W;
    localparam int IW   = cpo_pkg::IDX_W;
    localparam int SW   = cpo_pkg::SIZE_W;
    localparam int NW   = cpo_pkg::NB_W;

    logic [CW-1:0]   map_mem [MAX_POINTS];
    cpo_pkg::curve_t curve_mem [MAX_CURVES];

    cpo_pkg::func_t  fn;
    logic            acc;
    logic            map_we;
    logic            curve_we;
    logic            is_query;
    logic [PW-1:0]   map_addr;

    logic signed [W-1:0] pidx_w;
    logic signed [W-1:0] off_w;
    logic signed [W-1:0] np_w;
    logic signed [W-1:0] point_w;
    logic signed [W-1:0] np_m1_w;
    logic [PW:0]         np;
    logic [PW-1:0]       np_m1;
    logic [PW-1:0]       point;
    logic                in_range;

    logic                s1_v_reg;
    logic                s2_v_reg;
    logic signed [W-1:0] s1_shift_reg;
    logic signed [W-1:0] s1_shift_next;
    logic signed [W-1:0] s2_shift_reg;
    logic                s1_inr_reg;
    logic                s2_inr_reg;
    logic [CW-1:0]       map_rd_reg;
    cpo_pkg::curve_t     curve_rd_reg;

    logic signed [W-1:0] start_w;
    logic signed [W-1:0] end_w;
    logic [SW:0]         end_sum;
    logic                in_curve;
    logic [CNTW:0]       occ;

    // restoring reduction of a stored curve number into the table range
    function automatic logic [CW-1:0] wrap_curve(input logic [cpo_pkg::CIDX_W-1:0] v);
        logic [31:0] r;
        logic [31:0] m;
        r = 32'(v);
        for (int k = 7; k >= 0; k--)
        begin
            m = 32'(MAX_CURVES) << k;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return CW'(r);
    endfunction

    assign fn       = cpo_pkg::func_t'(item.func);
    assign acc      = item.valid && item.ready;
    assign map_addr = PW'(item.point_index[IW-2:0]);

    assign occ        = (CNTW+1)'(queue_count) + (CNTW+1)'(s1_v_reg) + (CNTW+1)'(s2_v_reg);
    assign item.ready = occ < (CNTW+1)'(QUEUE_DEPTH);

    always_comb
    begin
        map_we   = 1'b0;
        curve_we = 1'b0;
        is_query = 1'b0;
        unique case (fn)
            cpo_pkg::FUNC_MAP_LOAD:
            begin
                map_we = acc && !item.point_index[IW-1]
                         && (32'(item.point_index[IW-2:0]) < MAX_POINTS);
            end
            cpo_pkg::FUNC_CURVE_LOAD:
            begin
                curve_we = acc && (32'(item.curve_index) < MAX_CURVES);
            end
            cpo_pkg::FUNC_QUERY:
            begin
                is_query = acc;
            end
            default:
            begin
                is_query = 1'b0;
            end
        endcase
    end

    // effective point count and index clamp
    always_comb
    begin
        if (points_in_use == '0)
        begin
            np = (PW+1)'(1);
        end
        else if (32'(points_in_use) > MAX_POINTS)
        begin
            np = (PW+1)'(MAX_POINTS);
        end
        else
        begin
            np = (PW+1)'(points_in_use);
        end
    end

    assign np_m1   = PW'(np - (PW+1)'(1));
    assign np_w    = W'(np);
    assign np_m1_w = W'(np_m1);
    assign pidx_w  = {{(W-IW){item.point_index[IW-1]}}, item.point_index};
    assign off_w   = {{(W-IW){item.offset[IW-1]}}, item.offset};
    assign in_range = !item.point_index[IW-1] && (pidx_w < np_w);

    always_comb
    begin
        if (item.point_index[IW-1])
        begin
            point = '0;
        end
        else if (in_range)
        begin
            point = PW'(item.point_index[IW-2:0]);
        end
        else
        begin
            point = np_m1;
        end
    end

    assign point_w       = W'(point);
    assign s1_shift_next = point_w + off_w;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_addr] <= wrap_curve(item.curve_index);
        end
        map_rd_reg <= map_mem[point];
    end

    always_ff @(posedge clk)
    begin
        if (curve_we)
        begin
            curve_mem[CW'(item.curve_index)] <= '{closed: item.cyclic,
                                                  start:  item.curve_start,
                                                  size:   item.curve_size};
        end
        curve_rd_reg <= curve_mem[map_rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= is_query;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_shift_reg <= s1_shift_next;
        s1_inr_reg   <= in_range;
        s2_shift_reg <= s1_shift_reg;
        s2_inr_reg   <= s1_inr_reg;
    end

    // classification against the curve entry
    assign start_w  = W'(curve_rd_reg.start);
    assign end_sum  = (SW+1)'(curve_rd_reg.start) + (SW+1)'(curve_rd_reg.size);
    assign end_w    = W'(end_sum);
    assign in_curve = (s2_shift_reg >= start_w) && (s2_shift_reg < end_w);

    always_comb
    begin
        push_data.closed = curve_rd_reg.closed;
        push_data.ok     = s2_inr_reg && (curve_rd_reg.closed || in_curve);
        push_data.start  = curve_rd_reg.start;
        push_data.size   = curve_rd_reg.size;
        push_data.x      = s2_shift_reg - start_w;
        if (s2_shift_reg[W-1])
        begin
            push_data.nb_open = '0;
        end
        else if (s2_shift_reg > np_m1_w)
        begin
            push_data.nb_open = NW'(np_m1);
        end
        else
        begin
            push_data.nb_open = NW'(s2_shift_reg);
        end
    end

    assign push = s2_v_reg;

endmodule

// File: src/cpo_queue.sv
module cpo_queue #(
    parameter int unsigned DEPTH = cpo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  cpo_pkg::work_t                 push_data,
    input  logic                           pop,
    output cpo_pkg::work_t                 head,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cpo_pkg::work_t  entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// File: src/cpo_back.sv
module cpo_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cpo_pkg::work_t   head,
    input  logic             empty,
    output logic             pop,
    cpo_out_if.source        result
);

    localparam int W  = cpo_pkg::WORK_W;
    localparam int SW = cpo_pkg::SIZE_W;
    localparam int NW = cpo_pkg::NB_W;

    cpo_pkg::div_t   st_reg [W+1];
    logic            v_reg  [W+1];
    cpo_pkg::div_t   st0_next;
    cpo_pkg::div_t   fin;
    logic            adv;
    logic            out_v_reg;
    logic [NW-1:0]   nb_reg;
    logic            ok_reg;
    logic [NW-1:0]   nb_next;
    logic [SW-1:0]   m;
    logic [SW-1:0]   r;

    // one quotient bit of |x| / size per stage, remainder kept
    function automatic cpo_pkg::div_t div_step(input cpo_pkg::div_t s);
        cpo_pkg::div_t n;
        logic [SW:0]   t;
        n = s;
        t = {s.rem[SW-1:0], s.mag[W-1]};
        if (t >= {1'b0, s.size})
        begin
            t = t - {1'b0, s.size};
        end
        n.rem = t;
        n.mag = {s.mag[W-2:0], 1'b0};
        return n;
    endfunction

    assign adv = !out_v_reg || result.ready;
    assign pop = adv && !empty;

    always_comb
    begin
        st0_next.closed  = head.closed;
        st0_next.ok      = head.ok;
        st0_next.neg     = head.x[W-1];
        st0_next.start   = head.start;
        st0_next.size    = head.size;
        st0_next.nb_open = head.nb_open;
        st0_next.mag     = head.x[W-1] ? W'(-head.x) : W'(head.x);
        st0_next.rem     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= pop;
            for (int k = 0; k < W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            out_v_reg <= v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= st0_next;
            for (int k = 0; k < W; k++)
            begin
                st_reg[k+1] <= div_step(st_reg[k]);
            end
            nb_reg <= nb_next;
            ok_reg <= fin.ok;
        end
    end

    // truncated remainder to periodic remainder, then back to a point index
    assign fin = st_reg[W];
    assign m   = fin.rem[SW-1:0];

    always_comb
    begin
        if (fin.size == '0)
        begin
            r = '0;
        end
        else if (fin.neg && (m != '0))
        begin
            r = fin.size - m;
        end
        else
        begin
            r = m;
        end
        if (fin.closed)
        begin
            nb_next = NW'((SW+1)'(fin.start) + (SW+1)'(r));
        end
        else
        begin
            nb_next = fin.nb_open;
        end
    end

    assign result.valid          = out_v_reg;
    assign result.neighbor_index = nb_reg;
    assign result.valid_offset   = ok_reg;

endmodule

// File: src/curve_point_offset_index.sv
// curve_point_offset_index
//
// item channel (valid/ready): func selects a point map load, a curve table load
// or a query. loads update the tables and give no result. a query returns one
// transfer on the result channel: the offset point index along its curve
// (wrapping on closed curves, clamped to the used point range on open ones)
// and a flag saying whether the offset point is still a point of that curve.
// cfg_wr_en/cfg_wr_data set the number of points in use; write it while idle.
//
// throughput: one item per cycle while item.ready is high. a query's result
// leaves through the remainder pipeline of the back end, which resolves one bit
// of the wrap per stage.
// a load is visible to a query accepted in the next cycle.
// reset: points in use returns to 1, all pipelines empty; the point map and
// the curve table hold nothing defined until loaded, and no clearing is done.
// a stalled result channel holds its result; the pipeline and the queue in
// front of it fill, and item.ready drops once the queue cannot take more.
module curve_point_offset_index #(
    parameter int unsigned MAX_POINTS  = cpo_pkg::MAX_POINTS_DEF,
    parameter int unsigned MAX_CURVES  = cpo_pkg::MAX_CURVES_DEF,
    parameter int unsigned QUEUE_DEPTH = cpo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cpo_pkg::CFG_W-1:0]   cfg_wr_data,
    cpo_in_if.sink                      item,
    cpo_out_if.source                   result
);

    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [cpo_pkg::CFG_W-1:0] points_in_use_reg;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    logic [CNTW-1:0]           q_count;
    cpo_pkg::work_t            q_in;
    cpo_pkg::work_t            q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= cpo_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            points_in_use_reg <= cfg_wr_data;
        end
    end

    cpo_front #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_CURVES  (MAX_CURVES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .points_in_use (points_in_use_reg),
        .queue_count   (q_count),
        .push          (q_push),
        .push_data     (q_in)
    );

    cpo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    cpo_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .result (result)
    );

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ((32'(q_count) < QUEUE_DEPTH) || q_pop))
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("queue read while empty");

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_count == $past(q_count) + CNTW'(1)))
        else $error("queue count did not follow a lone write");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [cpo_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam longint IDX_MIN = -(longint'(1) << (cpo_pkg::IDX_W - 1));
    localparam longint IDX_MAX = (longint'(1) << (cpo_pkg::IDX_W - 1)) - 1;

    typedef struct packed {
        logic [cpo_pkg::FUNC_W-1:0]        func;
        logic signed [cpo_pkg::IDX_W-1:0]  point_index;
        logic signed [cpo_pkg::IDX_W-1:0]  offset;
        logic [cpo_pkg::CIDX_W-1:0]        curve_index;
        logic [cpo_pkg::START_W-1:0]       curve_start;
        logic [cpo_pkg::SIZE_W-1:0]        curve_size;
        logic                              cyclic;
    } cpo_item_t;

    typedef struct packed {
        logic [cpo_pkg::NB_W-1:0] nb;
        logic                     ok;
    } offset_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [cpo_pkg::CFG_W-1:0] cfg_wr_data;

    cpo_in_if  item_bus();
    cpo_out_if result_bus();

    curve_point_offset_index u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_bus),
        .result      (result_bus)
    );

    // mirror of the block's tables and register
    logic [cpo_pkg::CFG_W-1:0]  points_reg;
    logic [cpo_pkg::CIDX_W-1:0] curve_of [cpo_pkg::MAX_POINTS_DEF];
    bit                         map_loaded [cpo_pkg::MAX_POINTS_DEF];
    cpo_pkg::curve_t            curve_tab [cpo_pkg::MAX_CURVES_DEF];
    bit                         curve_loaded [cpo_pkg::MAX_CURVES_DEF];
    int                         mapped_pts[$];

    offset_result_t neighbor_queue[$];
    int             mismatches = 0;
    int             idle_cycles = 0;
    int             hold_request = 0;
    bit             src_gaps_on = 1'b1;
    bit             snk_gaps_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic longint points_limit();
        if (points_reg == 0)
            return 1;
        if (points_reg > cpo_pkg::MAX_POINTS_DEF)
            return cpo_pkg::MAX_POINTS_DEF;
        return points_reg;
    endfunction

    function automatic offset_result_t offset_neighbor(input longint pidx, input longint off);
        offset_result_t r;
        longint np;
        longint pt;
        longint shifted;
        longint lo;
        longint wrap;
        longint t;
        cpo_pkg::curve_t cv;
        np = points_limit();
        pt = (pidx < 0) ? 0 : ((pidx > np - 1) ? np - 1 : pidx);
        cv = curve_tab[curve_of[pt]];
        shifted = pt + off;
        if (cv.closed)
        begin
            wrap = 0;
            if (cv.size != 0)
            begin
                wrap = (shifted - longint'(cv.start)) % longint'(cv.size);
                if (wrap < 0)
                    wrap = wrap + longint'(cv.size);
            end
            lo = longint'(cv.start) + wrap;
        end
        else
            lo = (shifted < 0) ? 0 : ((shifted > np - 1) ? np - 1 : shifted);
        r.nb = lo[cpo_pkg::NB_W-1:0];
        // flag path works on the raw index
        if (pidx < 0 || pidx >= np)
            r.ok = 1'b0;
        else
        begin
            cv = curve_tab[curve_of[pidx]];
            t = pidx + off;
            r.ok = cv.closed ||
                   (t >= longint'(cv.start) && t < longint'(cv.start) + longint'(cv.size));
        end
        return r;
    endfunction

    function automatic int gap_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic cpo_item_t random_item();
        cpo_item_t it;
        it.func        = cpo_pkg::FUNC_W'($urandom_range(0, 3));
        it.point_index = cpo_pkg::IDX_W'($urandom());
        it.offset      = cpo_pkg::IDX_W'($urandom());
        it.curve_index = cpo_pkg::CIDX_W'($urandom());
        it.curve_start = cpo_pkg::START_W'($urandom());
        it.curve_size  = cpo_pkg::SIZE_W'($urandom());
        it.cyclic      = 1'($urandom());
        return it;
    endfunction

    // point whose map entry and curve entry are both loaded
    function automatic bit pick_point(output int p);
        longint np;
        int cand;
        int k;
        np = points_limit();
        p = 0;
        for (k = 0; k < 32; k++)
        begin
            if (k % 2 == 0 && mapped_pts.size() != 0)
                cand = mapped_pts[$urandom_range(0, mapped_pts.size() - 1)];
            else
                cand = $urandom_range(0, np - 1);
            if (cand < np && map_loaded[cand] && curve_loaded[curve_of[cand]])
            begin
                p = cand;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_item(input cpo_item_t it);
        int gap;
        longint pa;
        offset_result_t res;
        gap = (src_gaps_on && $urandom_range(0, 3) == 0) ? gap_length() : 0;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.func        <= it.func;
        item_bus.point_index <= it.point_index;
        item_bus.offset      <= it.offset;
        item_bus.curve_index <= it.curve_index;
        item_bus.curve_start <= it.curve_start;
        item_bus.curve_size  <= it.curve_size;
        item_bus.cyclic      <= it.cyclic;
        do
            @(posedge clk);
        while (!item_bus.ready);
        pa = it.point_index;
        case (it.func)
            cpo_pkg::FUNC_MAP_LOAD:
                if (pa >= 0 && pa < longint'(cpo_pkg::MAX_POINTS_DEF))
                begin
                    if (!map_loaded[pa])
                        mapped_pts.push_back(int'(pa));
                    map_loaded[pa] = 1'b1;
                    curve_of[pa]   = it.curve_index;
                end
            cpo_pkg::FUNC_CURVE_LOAD:
            begin
                curve_tab[it.curve_index] = '{closed: it.cyclic, start: it.curve_start,
                                              size: it.curve_size};
                curve_loaded[it.curve_index] = 1'b1;
            end
            cpo_pkg::FUNC_QUERY:
            begin
                res = offset_neighbor(it.point_index, it.offset);
                neighbor_queue.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic load_map(input longint p, input int c);
        cpo_item_t it;
        it = random_item();
        it.func        = cpo_pkg::FUNC_MAP_LOAD;
        it.point_index = p[cpo_pkg::IDX_W-1:0];
        it.curve_index = cpo_pkg::CIDX_W'(c);
        send_item(it);
    endtask

    task automatic load_curve(input int c, input int s, input int n, input bit cyc);
        cpo_item_t it;
        it = random_item();
        it.func        = cpo_pkg::FUNC_CURVE_LOAD;
        it.curve_index = cpo_pkg::CIDX_W'(c);
        it.curve_start = cpo_pkg::START_W'(s);
        it.curve_size  = cpo_pkg::SIZE_W'(n);
        it.cyclic      = cyc;
        send_item(it);
    endtask

    task automatic query(input longint pidx, input longint off);
        cpo_item_t it;
        it = random_item();
        it.func        = cpo_pkg::FUNC_QUERY;
        it.point_index = pidx[cpo_pkg::IDX_W-1:0];
        it.offset      = off[cpo_pkg::IDX_W-1:0];
        send_item(it);
    endtask

    task automatic random_query();
        int p;
        int sel;
        longint np;
        longint pidx;
        longint off;
        np = points_limit();
        if (!pick_point(p))
            return;
        pidx = p;
        if (p == 0 && $urandom_range(0, 3) == 0)
            pidx = -longint'($urandom_range(1, 1 << (cpo_pkg::IDX_W - 1)));
        else if (p == np - 1 && $urandom_range(0, 3) == 0)
            pidx = p + longint'($urandom_range(1, IDX_MAX + 1 - np));
        sel = $urandom_range(0, 9);
        if (sel < 6)
            off = longint'($urandom_range(0, 4 * np + 8)) - (2 * np + 4);
        else if (sel < 8)
            off = longint'($urandom_range(0, (1 << cpo_pkg::IDX_W) - 1)) + IDX_MIN;
        else if (sel == 8)
            off = IDX_MIN;
        else
            off = IDX_MAX;
        query(pidx, off);
    endtask

    // one curve entry, some points mapped to it, sometimes an unused func or an out-of-range map load, then queries
    task automatic run_round(input int n_queries);
        longint np;
        int c;
        int s;
        int n;
        int k;
        bit fits;
        cpo_item_t it;
        np = points_limit();
        c = $urandom_range(0, cpo_pkg::MAX_CURVES_DEF - 1);
        fits = ($urandom_range(0, 4) != 0);
        if (fits)
        begin
            s = $urandom_range(0, np - 1);
            n = $urandom_range(1, (np - s < 40) ? np - s : 40);
        end
        else
        begin
            s = $urandom_range(0, (1 << cpo_pkg::START_W) - 1);
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, (1 << cpo_pkg::SIZE_W) - 1);
        end
        load_curve(c, s, n, 1'($urandom_range(0, 1)));
        if (fits && n <= 12)
            for (k = s; k < s + n; k++)
                load_map(k, c);
        else
            repeat (6)
                load_map(fits ? $urandom_range(s, s + n - 1) : $urandom_range(0, np - 1), c);
        if ($urandom_range(0, 2) == 0)
        begin
            load_map(0, c);
            load_map(np - 1, c);
        end
        case ($urandom_range(0, 7))
            0:
            begin
                it = random_item();
                it.func = FUNC_UNUSED;
                send_item(it);
            end
            1:
                if ($urandom_range(0, 1) == 0)
                    load_map(longint'($urandom_range(cpo_pkg::MAX_POINTS_DEF, IDX_MAX)), c);
                else
                    load_map(-longint'($urandom_range(1, 1 << (cpo_pkg::IDX_W - 1))), c);
            default: ;
        endcase
        repeat (n_queries) random_query();
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (neighbor_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_points(input int v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cpo_pkg::CFG_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        points_reg  = cpo_pkg::CFG_W'(v);
    endtask

    // runs with the reset value of points in use
    task automatic test_directed();
        cpo_item_t it;
        load_curve(255, 0, 0, 1'b1);
        load_map(0, 255);
        query(0, IDX_MIN);
        query(IDX_MIN, IDX_MAX);
        query(IDX_MAX, 0);
        it = '1;
        it.func = FUNC_UNUSED;
        send_item(it);
        load_map(-1, 0);
        load_map(cpo_pkg::MAX_POINTS_DEF, 0);
        load_map(IDX_MAX, 0);
        load_curve(0, 1023, 2047, 1'b0);
        load_map(0, 0);
        query(0, 1023);
        query(0, 1022);
        query(0, -1);
        load_curve(1, 1023, 2047, 1'b1);
        load_map(0, 1);
        query(0, -1);
        query(0, IDX_MAX);
        query(-5, 3);
        load_curve(1, 0, 1, 1'b0);
        query(0, 0);
    endtask

    task automatic test_register_extremes();
        int values[4];
        int i;
        values = '{0, 2047, 1024, 1};
        for (i = 0; i < 4; i++)
        begin
            set_points(values[i]);
            src_gaps_on = (i != 1);
            snk_gaps_on = (i != 2);
            repeat (4) run_round(8);
        end
    endtask

    task automatic test_random_layouts();
        int values[7];
        int i;
        values = '{2, 7, 16, 33, 300, 1023, 0};
        values[6] = $urandom_range(3, cpo_pkg::MAX_POINTS_DEF - 1);
        for (i = 0; i < 7; i++)
        begin
            set_points(values[i]);
            src_gaps_on = (i % 3 != 0);
            snk_gaps_on = (i % 2 == 0);
            if (i == 3)
            begin
                src_gaps_on = 1'b0;
                snk_gaps_on = 1'b0;
            end
            repeat (7) run_round(8);
        end
    endtask

    task automatic test_result_backpressure();
        set_points(64);
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        run_round(4);
        hold_request = HOLD_CYCLES;
        repeat (48) random_query();
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        repeat (2) run_round(8);
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.func        <= '0;
        item_bus.point_index <= '0;
        item_bus.offset      <= '0;
        item_bus.curve_index <= '0;
        item_bus.curve_start <= '0;
        item_bus.curve_size  <= '0;
        item_bus.cyclic      <= 1'b0;
        points_reg = cpo_pkg::CFG_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_layouts();
        test_result_backpressure();
        settle();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // result side ready, with random stalls and the long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && snk_gaps_on && $urandom_range(0, 5) == 0)
                stall_left = gap_length();
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_result
        offset_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (neighbor_queue.size() == 0)
            begin
                $display("%0t: unexpected transfer: neighbor_index %0d valid_offset %0b",
                         $time, result_bus.neighbor_index, result_bus.valid_offset);
                mismatches++;
            end
            else
            begin
                want = neighbor_queue.pop_front();
                if (result_bus.neighbor_index !== want.nb || result_bus.valid_offset !== want.ok)
                begin
                    $display("%0t: expected neighbor_index %0d valid_offset %0b, actual %0d %0b",
                             $time, want.nb, want.ok,
                             result_bus.neighbor_index, result_bus.valid_offset);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: filelist.f
src/cpo_pkg.sv
src/cpo_in_if.sv
src/cpo_out_if.sv
src/cpo_front.sv
src/cpo_queue.sv
src/cpo_back.sv
src/curve_point_offset_index.sv
verif/testbench.sv
